[design/wsta_pkg.sv]
// shared constants, codes and types for the weighted server task assigner
package wsta_pkg;

  localparam int NUM_SERVERS = 16;
  localparam int IDX_W       = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam int CNT_W       = 5;
  localparam int OP_W        = 2;
  localparam int SIDX_W      = 4;
  localparam int WEIGHT_W    = 16;
  localparam int DUR_W       = 16;
  localparam int TIME_W      = 32;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [CNT_W-1:0]  SERVERS_RESET = CNT_W'(16);

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_TASK  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [IDX_W-1:0]    idx;
    logic [TIME_W-1:0]   start;
    logic [WEIGHT_W-1:0] weight;
  } scan_best_t;

  typedef struct packed {
    logic             first;
    logic             en;
    logic [IDX_W-1:0] idx;
  } scan_ctrl_t;

endpackage

[design/wsta_if.sv]
// handshake interfaces for the task input and result output channels
interface wsta_task_if;
  logic                           valid;
  logic                           ready;
  logic [wsta_pkg::OP_W-1:0]      op;
  logic [wsta_pkg::SIDX_W-1:0]    server_index;
  logic [wsta_pkg::WEIGHT_W-1:0]  weight_value;
  logic [wsta_pkg::DUR_W-1:0]     duration;

  modport source (output valid, op, server_index, weight_value, duration, input ready);
  modport sink (input valid, op, server_index, weight_value, duration, output ready);
endinterface

interface wsta_result_if;
  logic                         valid;
  logic                         ready;
  logic [wsta_pkg::SIDX_W-1:0]  assigned_server;
  logic [wsta_pkg::TIME_W-1:0]  finish_time;

  modport source (output valid, assigned_server, finish_time, input ready);
  modport sink (input valid, assigned_server, finish_time, output ready);
endinterface

[design/wsta_server_table.sv]
// per-server weight and busy-until registers with one read port
module wsta_server_table (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [wsta_pkg::IDX_W-1:0]         rd_idx,
  output logic [wsta_pkg::WEIGHT_W-1:0]      rd_weight,
  output logic [wsta_pkg::TIME_W-1:0]        rd_busy,
  input  logic                               weight_we,
  input  logic [wsta_pkg::IDX_W-1:0]         weight_idx,
  input  logic [wsta_pkg::WEIGHT_W-1:0]      weight_data,
  input  logic                               busy_we,
  input  logic [wsta_pkg::IDX_W-1:0]         busy_idx,
  input  logic [wsta_pkg::TIME_W-1:0]        busy_data,
  input  logic                               busy_clear
);

  logic [wsta_pkg::WEIGHT_W-1:0] weight [wsta_pkg::NUM_SERVERS];
  logic [wsta_pkg::TIME_W-1:0]   busy   [wsta_pkg::NUM_SERVERS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < wsta_pkg::NUM_SERVERS; i++) begin
        weight[i] <= '0;
        busy[i]   <= '0;
      end
    end else begin
      if (weight_we) begin
        weight[weight_idx] <= weight_data;
      end
      // clear item frees every server at once
      if (busy_clear) begin
        for (int i = 0; i < wsta_pkg::NUM_SERVERS; i++) begin
          busy[i] <= '0;
        end
      end else if (busy_we) begin
        busy[busy_idx] <= busy_data;
      end
    end
  end

  assign rd_weight = weight[rd_idx];
  assign rd_busy   = busy[rd_idx];

endmodule

[design/wsta_scan_unit.sv]
// shared key comparator that keeps the best server seen so far in a scan
module wsta_scan_unit (
  input  logic                           clk,
  input  wsta_pkg::scan_ctrl_t           ctrl,
  input  logic [wsta_pkg::TIME_W-1:0]    task_clock,
  input  logic [wsta_pkg::TIME_W-1:0]    cand_busy,
  input  logic [wsta_pkg::WEIGHT_W-1:0]  cand_weight,
  output wsta_pkg::scan_best_t           best
);

  logic [wsta_pkg::TIME_W-1:0] cand_start;
  logic                        take;

  always_comb begin
    cand_start = (cand_busy > task_clock) ? cand_busy : task_clock;
    // ties on start time go to the lower weight, then the lower index
    take = ctrl.first || (cand_start < best.start) ||
           ((cand_start == best.start) && (cand_weight < best.weight));
  end

  always_ff @(posedge clk) begin
    if (ctrl.en && take) begin
      best.idx    <= ctrl.idx;
      best.start  <= cand_start;
      best.weight <= cand_weight;
    end
  end

endmodule

[design/weighted_server_task_assigner.sv]
// top level: sequencer, task clock, config register and result register
//
//   channel  dir  handshake         payload
//   job      in   valid/ready       op, server_index, weight_value, duration
//   grant    out  valid/ready       assigned_server, finish_time
//   cfg      in   cfg_we            cfg_wdata (servers_in_use)
//
// a task is taken in, then the servers in use are scanned one at a time through the
// single comparator, and an update ends it
// load, clear and unused items are handled as they are taken in and give no result
// the result register holds a result until taken; an update waits while it is full
// no clearing pass: reset and clear items zero the busy times at once
module weighted_server_task_assigner (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [wsta_pkg::CNT_W-1:0]     cfg_wdata,
  wsta_task_if.sink                      job,
  wsta_result_if.source                  grant
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPDATE} state_t;

  state_t                         state;
  logic [wsta_pkg::IDX_W-1:0]     scan_idx;
  logic [wsta_pkg::TIME_W-1:0]    task_clock;
  logic [wsta_pkg::CNT_W-1:0]     servers_in_use;
  logic [wsta_pkg::DUR_W-1:0]     duration;
  logic                           out_valid;
  logic [wsta_pkg::SIDX_W-1:0]    out_server;
  logic [wsta_pkg::TIME_W-1:0]    out_finish;

  logic                           accept;
  logic [wsta_pkg::IDX_W-1:0]     last_idx;
  logic                           upd_go;
  logic [wsta_pkg::TIME_W:0]      sum;
  logic [wsta_pkg::TIME_W-1:0]    finish;
  logic                           weight_we;
  logic                           busy_clear;
  logic [wsta_pkg::WEIGHT_W-1:0]  rd_weight;
  logic [wsta_pkg::TIME_W-1:0]    rd_busy;
  wsta_pkg::scan_ctrl_t           ctrl;
  wsta_pkg::scan_best_t           best;

  assign job.ready = (state == S_IDLE);
  assign accept    = job.valid && job.ready;

  always_comb begin
    // zero acts as one, anything beyond the table acts as the table size
    if (servers_in_use == '0) begin
      last_idx = '0;
    end else if (32'(servers_in_use) > wsta_pkg::NUM_SERVERS) begin
      last_idx = wsta_pkg::IDX_W'(wsta_pkg::NUM_SERVERS - 1);
    end else begin
      last_idx = wsta_pkg::IDX_W'(servers_in_use - 1'b1);
    end
    weight_we  = accept && (job.op == wsta_pkg::OP_LOAD) &&
                 (32'(job.server_index) < wsta_pkg::NUM_SERVERS);
    busy_clear = accept && (job.op == wsta_pkg::OP_CLEAR);
    upd_go     = (state == S_UPDATE) && (!out_valid || grant.ready);
    sum        = {1'b0, best.start} + (wsta_pkg::TIME_W + 1)'(duration);
    finish     = sum[wsta_pkg::TIME_W] ? wsta_pkg::TIME_MAX : sum[wsta_pkg::TIME_W-1:0];
    ctrl.en    = (state == S_SCAN);
    ctrl.first = (scan_idx == '0);
    ctrl.idx   = scan_idx;
  end

  wsta_server_table u_table (
    .clk         (clk),
    .rst         (rst),
    .rd_idx      (scan_idx),
    .rd_weight   (rd_weight),
    .rd_busy     (rd_busy),
    .weight_we   (weight_we),
    .weight_idx  (wsta_pkg::IDX_W'(job.server_index)),
    .weight_data (job.weight_value),
    .busy_we     (upd_go),
    .busy_idx    (best.idx),
    .busy_data   (finish),
    .busy_clear  (busy_clear)
  );

  wsta_scan_unit u_scan (
    .clk         (clk),
    .ctrl        (ctrl),
    .task_clock  (task_clock),
    .cand_busy   (rd_busy),
    .cand_weight (rd_weight),
    .best        (best)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      scan_idx       <= '0;
      task_clock     <= '0;
      servers_in_use <= wsta_pkg::SERVERS_RESET;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        servers_in_use <= cfg_wdata;
      end
      if (out_valid && grant.ready && !upd_go) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (job.op)
              wsta_pkg::OP_TASK: begin
                duration <= job.duration;
                scan_idx <= '0;
                state    <= S_SCAN;
              end
              wsta_pkg::OP_CLEAR: begin
                task_clock <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_idx == last_idx) begin
            state <= S_UPDATE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_UPDATE: begin
          if (upd_go) begin
            out_valid  <= 1'b1;
            out_server <= wsta_pkg::SIDX_W'(best.idx);
            out_finish <= finish;
            if (task_clock != wsta_pkg::TIME_MAX) begin
              task_clock <= task_clock + 1'b1;
            end
            scan_idx <= '0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign grant.valid           = out_valid;
  assign grant.assigned_server = out_server;
  assign grant.finish_time     = out_finish;

`ifndef NO_ASSERTIONS
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_idx <= last_idx))
    else $error("scan index beyond the servers in use");

  a_update_loads: assert property (@(posedge clk) disable iff (rst)
    upd_go |=> (out_valid && (out_finish >= $past(best.start))))
    else $error("update did not load a result at or after its start time");

  a_clock_monotonic: assert property (@(posedge clk) disable iff (rst)
    !busy_clear |=> (task_clock >= $past(task_clock)))
    else $error("task clock went back without a clear");

  a_no_busy_write_on_clear: assert property (@(posedge clk) disable iff (rst)
    busy_clear |-> !upd_go)
    else $error("clear and busy update in the same cycle");
`endif

endmodule
